### design/lom_pkg.sv
// Shared types and constants of the limit order matcher.
// Used by lom_front, lom_engine, limit_order_matcher, lom_checker and tb; no dependencies.
package lom_pkg;

    localparam int unsigned ORDER_SLOTS_DEF  = 32;
    localparam int unsigned PRICE_LEVELS_DEF = 1024;

    localparam int unsigned PRICE_W = 10;
    localparam int unsigned QTY_W   = 16;
    localparam int unsigned TRADER_W = 16;
    localparam int unsigned OID_W   = 5;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 72;

    localparam logic [STAT_W-1:0] STAT_RESTED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FILLED   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECTED = 2'd2;

    localparam logic KIND_FILL  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [1:0] {
        CMD_MATCH,
        CMD_REJECT,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic                  side;
        logic [PRICE_W-1:0]    price;
        logic [QTY_W-1:0]      qty;
        logic [TRADER_W-1:0]   trader;
    } cmd_t;

endpackage

### design/lom_front.sv
// Front part: accepts orders, classifies them and queues them for the engine.
// Depends on lom_pkg.
module lom_front #(
    parameter int unsigned PRICE_LEVELS = lom_pkg::PRICE_LEVELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lom_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    output logic                          cmd_valid,
    output lom_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);
    lom_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    lom_pkg::cmd_t in_cmd;
    logic          push;

    always_comb begin
        in_cmd.side   = s_tuser;
        in_cmd.price  = s_tdata[9:0];
        in_cmd.qty    = s_tdata[25:10];
        in_cmd.trader = s_tdata[41:26];
        priority if (32'(in_cmd.price) >= PRICE_LEVELS) begin
            in_cmd.kind = lom_pkg::CMD_REJECT;
        end else if (in_cmd.qty == '0) begin
            in_cmd.kind = lom_pkg::CMD_EMPTY;
        end else begin
            in_cmd.kind = lom_pkg::CMD_MATCH;
        end
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= in_cmd;
                wr_ptr_reg        <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(cmd_pop);
        end
    end
endmodule

### design/lom_engine.sv
// Back part: walks the book, emits fills and rests remainders.
// Holds slot data, free stack and the occupied-level table. Depends on lom_pkg.
module lom_engine #(
    parameter int unsigned ORDER_SLOTS = lom_pkg::ORDER_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  lom_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lom_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    localparam int unsigned SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int unsigned CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(ORDER_SLOTS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FILL, ST_FINAL} state_t;

    state_t state_reg;
    lom_pkg::cmd_t cmd_reg;
    logic [lom_pkg::QTY_W-1:0] rem_reg;
    logic [SW-1:0] touched_reg, idx_reg;

    // slot data
    logic [lom_pkg::QTY_W-1:0]    sq_reg [ORDER_SLOTS];
    logic [lom_pkg::TRADER_W-1:0] st_reg [ORDER_SLOTS];
    logic [SW-1:0]                sn_reg [ORDER_SLOTS];
    logic                         snv_reg [ORDER_SLOTS];
    logic [SW-1:0]                stack_reg [ORDER_SLOTS];
    logic [CW-1:0]                fc_reg;

    // occupied levels, at most one per resting order
    logic                         lv_valid_reg [ORDER_SLOTS];
    logic                         lv_side_reg  [ORDER_SLOTS];
    logic [lom_pkg::PRICE_W-1:0]  lv_price_reg [ORDER_SLOTS];
    logic [SW-1:0]                lv_head_reg  [ORDER_SLOTS];
    logic [SW-1:0]                lv_tail_reg  [ORDER_SLOTS];

    logic best_found_reg, own_found_reg, free_found_reg;
    logic [SW-1:0] best_idx_reg, own_idx_reg, free_idx_reg;
    logic [lom_pkg::PRICE_W-1:0] best_price_reg;

    logic out_valid_reg, out_kind_reg, out_last_reg;
    logic [lom_pkg::M_DATA_W-1:0] out_data_reg;

    logic out_free, out_load;
    logic e_cross, e_better, e_take, e_own;
    logic [lom_pkg::PRICE_W-1:0] e_price;
    logic [SW-1:0] hs, pop_s;
    logic [lom_pkg::QTY_W-1:0] hq, fill, newq, newrem;

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == ST_FILL) || (state_reg == ST_FINAL));
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;

    always_comb begin
        e_price  = lv_price_reg[idx_reg];
        e_cross  = (cmd_reg.side == lom_pkg::SIDE_BUY) ? (e_price <= cmd_reg.price)
                                                       : (e_price >= cmd_reg.price);
        e_better = (cmd_reg.side == lom_pkg::SIDE_BUY) ? (e_price < best_price_reg)
                                                       : (e_price > best_price_reg);
        e_take   = lv_valid_reg[idx_reg] && (lv_side_reg[idx_reg] != cmd_reg.side)
                   && e_cross && (!best_found_reg || e_better);
        e_own    = lv_valid_reg[idx_reg] && (lv_side_reg[idx_reg] == cmd_reg.side)
                   && (e_price == cmd_reg.price);
        hs       = lv_head_reg[best_idx_reg];
        hq       = sq_reg[hs];
        fill     = (hq < rem_reg) ? hq : rem_reg;
        newq     = hq - fill;
        newrem   = rem_reg - fill;
        pop_s    = stack_reg[SW'(fc_reg - CW'(1))];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fc_reg        <= CW'(ORDER_SLOTS);
            for (int i = 0; i < ORDER_SLOTS; i++) begin
                lv_valid_reg[i] <= 1'b0;
                stack_reg[i]    <= SW'(ORDER_SLOTS - 1 - i);
            end
        end else begin
            // drop a taken result unless a new one is loaded this cycle
            if (out_valid_reg && m_tready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg        <= cmd;
                        touched_reg    <= '0;
                        idx_reg        <= '0;
                        best_found_reg <= 1'b0;
                        own_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        rem_reg        <= (cmd.kind == lom_pkg::CMD_MATCH) ? cmd.qty : '0;
                        state_reg      <= (cmd.kind == lom_pkg::CMD_MATCH) ? ST_SCAN
                                                                           : ST_FINAL;
                    end
                end
                ST_SCAN: begin
                    if (e_take) begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= idx_reg;
                        best_price_reg <= e_price;
                    end
                    if (e_own) begin
                        own_found_reg <= 1'b1;
                        own_idx_reg   <= idx_reg;
                    end
                    if (!lv_valid_reg[idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    idx_reg <= idx_reg + SW'(1);
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= (e_take || best_found_reg) ? ST_FILL : ST_FINAL;
                    end
                end
                ST_FILL: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= lom_pkg::KIND_FILL;
                        out_last_reg  <= 1'b0;
                        out_data_reg  <= {7'd0, lom_pkg::STAT_RESTED, lom_pkg::OID_W'(hs),
                            (cmd_reg.side == lom_pkg::SIDE_BUY) ? st_reg[hs] : cmd_reg.trader,
                            (cmd_reg.side == lom_pkg::SIDE_BUY) ? cmd_reg.trader : st_reg[hs],
                            fill, cmd_reg.price};
                        sq_reg[hs]  <= newq;
                        rem_reg     <= newrem;
                        touched_reg <= hs;
                        if (newq == '0) begin
                            stack_reg[SW'(fc_reg)] <= hs;
                            fc_reg <= fc_reg + CW'(1);
                            if (snv_reg[hs]) begin
                                lv_head_reg[best_idx_reg] <= sn_reg[hs];
                                state_reg <= (newrem != '0) ? ST_FILL : ST_FINAL;
                            end else begin
                                // level emptied: look for the next best one
                                lv_valid_reg[best_idx_reg] <= 1'b0;
                                idx_reg        <= '0;
                                best_found_reg <= 1'b0;
                                own_found_reg  <= 1'b0;
                                free_found_reg <= 1'b0;
                                state_reg <= (newrem != '0) ? ST_SCAN : ST_FINAL;
                            end
                        end else begin
                            state_reg <= ST_FINAL;
                        end
                    end
                end
                ST_FINAL: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= lom_pkg::KIND_FINAL;
                        out_last_reg  <= 1'b1;
                        priority if (cmd_reg.kind == lom_pkg::CMD_REJECT) begin
                            out_data_reg <= {7'd0, lom_pkg::STAT_REJECTED, 63'd0};
                        end else if (rem_reg == '0) begin
                            out_data_reg <= {7'd0, lom_pkg::STAT_FILLED,
                                lom_pkg::OID_W'(touched_reg), 58'd0};
                        end else if (fc_reg == '0) begin
                            out_data_reg <= {7'd0, lom_pkg::STAT_REJECTED,
                                lom_pkg::OID_W'(touched_reg), 58'd0};
                        end else begin
                            out_data_reg <= {7'd0, lom_pkg::STAT_RESTED,
                                lom_pkg::OID_W'(pop_s), 58'd0};
                            fc_reg         <= fc_reg - CW'(1);
                            sq_reg[pop_s]  <= rem_reg;
                            st_reg[pop_s]  <= cmd_reg.trader;
                            snv_reg[pop_s] <= 1'b0;
                            if (own_found_reg) begin
                                sn_reg[lv_tail_reg[own_idx_reg]]  <= pop_s;
                                snv_reg[lv_tail_reg[own_idx_reg]] <= 1'b1;
                                lv_tail_reg[own_idx_reg]          <= pop_s;
                            end else begin
                                lv_valid_reg[free_idx_reg] <= 1'b1;
                                lv_side_reg[free_idx_reg]  <= cmd_reg.side;
                                lv_price_reg[free_idx_reg] <= cmd_reg.price;
                                lv_head_reg[free_idx_reg]  <= pop_s;
                                lv_tail_reg[free_idx_reg]  <= pop_s;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### design/limit_order_matcher.sv
// Top level of the limit order matcher: front queue plus matching engine.
// Depends on lom_pkg, lom_front and lom_engine.
//
// Usage:
//   s_ channel carries one limit order per transaction: s_tuser is the side
//   (0 buy, 1 sell), s_tdata holds price, quantity and trader.
//   m_ channel returns one transaction per fill (m_tuser 0) followed by one
//   final outcome (m_tuser 1, m_tlast 1) holding status and order id.
//   A two-entry queue sits between the input and the engine, so orders are
//   taken while the engine works or while a result waits on m_tready.
//   Timing: an order that matches is scanned against the occupied-level
//   table, one entry per cycle; each fill then waits for the output to be
//   free, and a fill that empties a level while a remainder is left costs
//   another table scan. Orders rejected for price or of zero size skip the
//   scan and go straight to the final outcome.
//   Reset empties the book and the queue and drops any pending result.
//   While m_tready is low the engine holds its result and stalls on its next
//   output but may still scan; the input stays open until the queue fills.
module limit_order_matcher #(
    parameter int unsigned ORDER_SLOTS  = lom_pkg::ORDER_SLOTS_DEF,
    parameter int unsigned PRICE_LEVELS = lom_pkg::PRICE_LEVELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lom_pkg::S_DATA_W-1:0]  s_tdata,  // price, quantity, trader, zero pad
    input  logic                          s_tuser,  // side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fill price, fill size, buyer_id, seller_id, order_id, status, zero pad
    output logic [lom_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,  // kind
    output logic                          m_tlast
);
    logic          cmd_valid, cmd_pop;
    lom_pkg::cmd_t cmd;

    lom_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .cmd_valid, .cmd, .cmd_pop
    );

    lom_engine #(.ORDER_SLOTS(ORDER_SLOTS)) u_engine (
        .aclk, .aresetn, .cmd_valid, .cmd, .cmd_pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

`ifndef SYNTH
    a_no_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == lom_pkg::KIND_FILL) |-> m_tdata[25:10] != '0)
        else $error("zero-size trade");
    a_last_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == lom_pkg::KIND_FINAL)))
        else $error("last flag disagrees with kind");
    a_fill_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == lom_pkg::KIND_FILL) |-> m_tdata[64:63] == '0)
        else $error("fill carries a status");
`endif
endmodule

### tb/lom_checker.sv
// Book predictor and result scoreboard for the limit order matcher.
// Depends on lom_pkg; watches the s_ and m_ channels of the block.
module lom_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lom_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lom_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tuser,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            outstanding,
    output int                            fills_seen,
    output int                            rests_seen,
    output int                            rejects_seen
);
    localparam int SLOTS  = lom_pkg::ORDER_SLOTS_DEF;
    localparam int LEVELS = lom_pkg::PRICE_LEVELS_DEF;
    localparam int NIL    = 63;

    typedef struct packed {
        logic                         kind;
        logic [lom_pkg::PRICE_W-1:0]  fill_price;
        logic [lom_pkg::QTY_W-1:0]    fill_qty;
        logic [lom_pkg::TRADER_W-1:0] buyer;
        logic [lom_pkg::TRADER_W-1:0] seller;
        logic [lom_pkg::OID_W-1:0]    oid;
        logic [lom_pkg::STAT_W-1:0]   status;
        logic                         last;
    } book_event_t;

    book_event_t expected_events[$];

    int       rest_qty[SLOTS];
    int       rest_trader[SLOTS];
    int       rest_next[SLOTS];
    int       free_stack[SLOTS];
    int       free_top;
    int       head[LEVELS];
    int       tail[LEVELS];
    bit       bid_busy[LEVELS];
    bit       ask_busy[LEVELS];

    task automatic empty_level(input int l);
        head[l] = NIL;
        tail[l] = NIL;
        bid_busy[l] = 0;
        ask_busy[l] = 0;
    endtask

    task automatic book_clear();
        for (int i = 0; i < SLOTS; i++) begin
            rest_qty[i] = 0;
            rest_trader[i] = 0;
            rest_next[i] = 0;
            free_stack[i] = SLOTS - 1 - i;
        end
        free_top = SLOTS;
        for (int l = 0; l < LEVELS; l++) empty_level(l);
    endtask

    function automatic book_event_t mk_event(logic kind, int tp, int ts, int buyer, int seller,
                                             int oid, logic [lom_pkg::STAT_W-1:0] st,
                                             logic last);
        book_event_t e;
        e.kind = kind;
        e.fill_price = tp[lom_pkg::PRICE_W-1:0];
        e.fill_qty = ts[lom_pkg::QTY_W-1:0];
        e.buyer = buyer[lom_pkg::TRADER_W-1:0];
        e.seller = seller[lom_pkg::TRADER_W-1:0];
        e.oid = oid[lom_pkg::OID_W-1:0];
        e.status = st;
        e.last = last;
        return e;
    endfunction

    // Walk the opposite side while it crosses, then rest, reject or close.
    task automatic match_order(input logic side, input int price, input int qty,
                               input int trader);
        int  rem, touched, lvl, s, fill, nx, n;
        bit  found;
        rem = qty;
        touched = 0;
        n = 0;
        forever begin
            if (rem == 0) break;
            found = 0;
            if (side == lom_pkg::SIDE_BUY) begin
                for (int i = 0; i <= price && !found; i++)
                    if (ask_busy[i]) begin found = 1; lvl = i; end
            end else begin
                for (int i = LEVELS - 1; i >= price && !found; i--)
                    if (bid_busy[i]) begin found = 1; lvl = i; end
            end
            if (!found) break;
            s = head[lvl];
            if (s >= SLOTS || n >= SLOTS) begin
                empty_level(lvl);
                continue;
            end
            fill = (rest_qty[s] < rem) ? rest_qty[s] : rem;
            if (side == lom_pkg::SIDE_BUY)
                expected_events.push_back(mk_event(lom_pkg::KIND_FILL, price, fill, trader,
                                                   rest_trader[s], s, lom_pkg::STAT_RESTED,
                                                   0));
            else
                expected_events.push_back(mk_event(lom_pkg::KIND_FILL, price, fill,
                                                   rest_trader[s], trader, s,
                                                   lom_pkg::STAT_RESTED, 0));
            n++;
            touched = s;
            rem -= fill;
            rest_qty[s] -= fill;
            if (rest_qty[s] == 0) begin
                nx = rest_next[s];
                if (nx >= SLOTS) empty_level(lvl);
                else head[lvl] = nx;
                if (free_top < SLOTS) begin
                    free_stack[free_top] = s;
                    free_top++;
                end
            end
        end
        if (qty == 0) begin
            expected_events.push_back(mk_event(lom_pkg::KIND_FINAL, 0, 0, 0, 0, 0,
                                               lom_pkg::STAT_FILLED, 1));
        end else if (rem == 0) begin
            expected_events.push_back(mk_event(lom_pkg::KIND_FINAL, 0, 0, 0, 0, touched,
                                               lom_pkg::STAT_FILLED, 1));
        end else if (free_top == 0) begin
            expected_events.push_back(mk_event(lom_pkg::KIND_FINAL, 0, 0, 0, 0, touched,
                                               lom_pkg::STAT_REJECTED, 1));
        end else begin
            free_top--;
            s = free_stack[free_top];
            rest_qty[s] = rem;
            rest_trader[s] = trader;
            rest_next[s] = NIL;
            if (tail[price] < SLOTS) rest_next[tail[price]] = s;
            else head[price] = s;
            tail[price] = s;
            if (side == lom_pkg::SIDE_BUY) bid_busy[price] = 1;
            else ask_busy[price] = 1;
            expected_events.push_back(mk_event(lom_pkg::KIND_FINAL, 0, 0, 0, 0, s,
                                               lom_pkg::STAT_RESTED, 1));
        end
    endtask

    assign outstanding = expected_events.size();

    always @(posedge aclk) begin
        book_event_t got, want;
        if (!aresetn) begin
            book_clear();
            expected_events.delete();
            mismatches = 0;
            fills_seen = 0;
            rests_seen = 0;
            rejects_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = mk_event(m_tuser, m_tdata[9:0], m_tdata[25:10], m_tdata[41:26],
                               m_tdata[57:42], m_tdata[62:58], m_tdata[64:63], m_tlast);
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result transaction %p", got);
                end else begin
                    want = expected_events.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                     want, got);
                    end
                end
                if (got.kind == lom_pkg::KIND_FILL) fills_seen++;
                else if (got.status == lom_pkg::STAT_RESTED) rests_seen++;
                else if (got.status == lom_pkg::STAT_REJECTED) rejects_seen++;
            end
            if (s_tvalid && s_tready)
                match_order(s_tuser, s_tdata[9:0], s_tdata[25:10], s_tdata[41:26]);
        end
    end
endmodule

### tb/tb.sv
// Stimulus and verdict for the limit order matcher.
// Depends on lom_pkg, limit_order_matcher and lom_checker.
module tb;
    localparam int CYCLE_LIMIT = 4000000;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [lom_pkg::S_DATA_W-1:0] s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [lom_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    int mismatches, outstanding, fills_seen, rests_seen, rejects_seen;
    int cycles = 0;
    int orders_sent;
    int ready_hold = 0;
    bit no_stall = 1'b0;

    limit_order_matcher u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    lom_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .mismatches(mismatches), .outstanding(outstanding), .fills_seen(fills_seen),
        .rests_seen(rests_seen), .rejects_seen(rejects_seen)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Some stretches run without any stall or gap.
    always @(posedge aclk) begin
        if (cycles % 300 == 0) no_stall <= ($urandom_range(0, 3) == 0);
    end

    // Receiver: draw a stall per result, hold tready low for the drawn length.
    always @(posedge aclk) begin
        int w;
        if (m_tvalid && m_tready) begin
            w = no_stall ? 0 : $urandom_range(0, 16);
            if (w > 0) begin
                m_tready <= 1'b0;
                ready_hold <= w - 1;
            end
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_order(input logic side, input int price, input int qty,
                              input int trader);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= side;
        s_tdata <= {6'd0, trader[15:0], qty[15:0], price[9:0]};
        do @(posedge aclk); while (!s_tready);
        orders_sent++;
    endtask

    initial begin
        int mode, side, price, qty;
        s_tvalid = 0;
        s_tuser = 0;
        s_tdata = '0;
        aresetn = 0;
        orders_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-book extremes, zero size, FIFO sweep, exact and partial fills.
        send_order(lom_pkg::SIDE_BUY, 0, 65535, 16'hFFFF);
        send_order(lom_pkg::SIDE_SELL, 1023, 65535, 0);
        send_order(lom_pkg::SIDE_BUY, 1023, 0, 16'h1234);
        send_order(lom_pkg::SIDE_SELL, 0, 1, 16'hAAAA);
        send_order(lom_pkg::SIDE_SELL, 500, 10, 16'h0011);
        send_order(lom_pkg::SIDE_SELL, 500, 20, 16'h0022);
        send_order(lom_pkg::SIDE_SELL, 501, 30, 16'h0033);
        send_order(lom_pkg::SIDE_BUY, 501, 25, 16'h5555);
        send_order(lom_pkg::SIDE_BUY, 501, 5, 16'h6666);
        send_order(lom_pkg::SIDE_BUY, 600, 100, 16'h7777);
        send_order(lom_pkg::SIDE_BUY, 400, 40, 16'h0101);
        send_order(lom_pkg::SIDE_BUY, 400, 40, 16'h0202);
        send_order(lom_pkg::SIDE_SELL, 300, 80, 16'h0303);
        send_order(lom_pkg::SIDE_SELL, 0, 65535, 16'hFFFF);
        send_order(lom_pkg::SIDE_BUY, 1023, 65535, 16'h8000);
        send_order(lom_pkg::SIDE_SELL, 1023, 1, 16'h0001);

        // Random: passive phases fill the book to rejection, sweeps drain it.
        for (int blk = 0; blk < 12; blk++) begin
            mode = $urandom_range(0, 2);
            for (int k = 0; k < 38; k++) begin
                side = $urandom_range(0, 1);
                case (mode)
                    0: price = $urandom_range(480, 520);
                    1: price = side ? $urandom_range(700, 900) : $urandom_range(100, 300);
                    default: price = side ? $urandom_range(0, 600) : $urandom_range(400, 1023);
                endcase
                if ($urandom_range(0, 9) == 0) price = $urandom_range(0, 1023);
                qty = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 300);
                send_order(side[0], price, qty, $urandom_range(0, 65535));
            end
        end
        s_tvalid <= 1'b0;

        // let the checker log the last order before waiting on the results
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d orders: %0d fills, %0d rested, %0d rejected.",
                 orders_sent, fills_seen, rests_seen, rejects_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
